[src/cbez_pkg.sv]
package cbez_pkg;

    localparam int STEP_COUNT  = 20;
    localparam int COORD_W     = 20;
    localparam int WEIGHT_W    = 17;
    localparam int ONE_Q16     = 65536;
    localparam int K_W         = $clog2(STEP_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [K_W-1:0] step_t;

    typedef struct packed {
        coord_t [3:0] x;
        coord_t [3:0] y;
    } ctrl_set_t;

    typedef weight_t weight_arr_t [STEP_COUNT];

    function automatic weight_arr_t build_weights();
        weight_arr_t tbl;
        for (int k = 0; k < STEP_COUNT; k++) begin
            tbl[k] = WEIGHT_W'((k * ONE_Q16 + STEP_COUNT / 2) / STEP_COUNT);
        end
        return tbl;
    endfunction

    localparam weight_arr_t WEIGHT_TABLE = build_weights();

    function automatic coord_t lerp_q16(coord_t a, coord_t b, weight_t w);
        logic signed [WEIGHT_W:0] ws;
        logic signed [WEIGHT_W:0] w1s;
        logic signed [COORD_W+WEIGHT_W:0] p0;
        logic signed [COORD_W+WEIGHT_W:0] p1;
        logic signed [COORD_W+WEIGHT_W+1:0] s;
        ws  = signed'({1'b0, w});
        w1s = (WEIGHT_W+1)'(ONE_Q16) - ws;
        p0  = a * w1s;
        p1  = b * ws;
        s   = (COORD_W+WEIGHT_W+2)'(p0) + (COORD_W+WEIGHT_W+2)'(p1)
            + (COORD_W+WEIGHT_W+2)'(ONE_Q16 / 2);
        return s[COORD_W+15:16];
    endfunction

endpackage

[src/cbez_front.sv]
module cbez_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cbez_pkg::ctrl_set_t s_set,
    output cbez_pkg::ctrl_set_t head_data,
    output logic               head_valid,
    input  logic               head_pop
);
    import cbez_pkg::*;

    ctrl_set_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic                 push;
    logic                 pop;

    always_comb begin
        s_ready    = (count_reg != QCNT_W'(QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head_data  = mem[rd_ptr_reg];
        push       = s_valid && s_ready;
        pop        = head_pop && head_valid;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_set;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

[src/cbez_back.sv]
module cbez_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  cbez_pkg::ctrl_set_t head_data,
    input  logic                head_valid,
    output logic                head_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output cbez_pkg::coord_t    m_curve_x,
    output cbez_pkg::coord_t    m_curve_y,
    output logic                m_last_point
);
    import cbez_pkg::*;

    localparam step_t K_LAST = K_W'(STEP_COUNT - 1);

    logic      en;
    logic      issue;
    step_t     k_reg;
    step_t     k_next;

    logic      s0_valid_reg;
    ctrl_set_t s0_set_reg;
    weight_t   s0_w_reg;
    logic      s0_last_reg;

    logic      s1_valid_reg;
    coord_t    s1_x_reg [3];
    coord_t    s1_y_reg [3];
    weight_t   s1_w_reg;
    logic      s1_last_reg;

    logic      s2_valid_reg;
    coord_t    s2_x_reg [2];
    coord_t    s2_y_reg [2];
    weight_t   s2_w_reg;
    logic      s2_last_reg;

    logic      out_valid_reg;
    coord_t    out_x_reg;
    coord_t    out_y_reg;
    logic      out_last_reg;

    coord_t    l1_x [3];
    coord_t    l1_y [3];
    coord_t    l2_x [2];
    coord_t    l2_y [2];

    always_comb begin
        en       = !out_valid_reg || m_ready;
        issue    = en && head_valid;
        head_pop = issue && (k_reg == K_LAST);
        if (!issue) begin
            k_next = k_reg;
        end else if (k_reg == K_LAST) begin
            k_next = '0;
        end else begin
            k_next = k_reg + 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            l1_x[i] = lerp_q16(s0_set_reg.x[i], s0_set_reg.x[i+1], s0_w_reg);
            l1_y[i] = lerp_q16(s0_set_reg.y[i], s0_set_reg.y[i+1], s0_w_reg);
        end
        for (int i = 0; i < 2; i++) begin
            l2_x[i] = lerp_q16(s1_x_reg[i], s1_x_reg[i+1], s1_w_reg);
            l2_y[i] = lerp_q16(s1_y_reg[i], s1_y_reg[i+1], s1_w_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            k_reg <= k_next;
            if (en) begin
                s0_valid_reg  <= issue;
                s1_valid_reg  <= s0_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_set_reg  <= head_data;
            s0_w_reg    <= WEIGHT_TABLE[k_reg];
            s0_last_reg <= (k_reg == K_LAST);
            s1_x_reg    <= l1_x;
            s1_y_reg    <= l1_y;
            s1_w_reg    <= s0_w_reg;
            s1_last_reg <= s0_last_reg;
            s2_x_reg    <= l2_x;
            s2_y_reg    <= l2_y;
            s2_w_reg    <= s1_w_reg;
            s2_last_reg <= s1_last_reg;
            out_x_reg    <= lerp_q16(s2_x_reg[0], s2_x_reg[1], s2_w_reg);
            out_y_reg    <= lerp_q16(s2_y_reg[0], s2_y_reg[1], s2_w_reg);
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_curve_x    = out_x_reg;
    assign m_curve_y    = out_y_reg;
    assign m_last_point = out_last_reg;

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> head_valid && en)
        else $error("pop without a queued control set");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= K_LAST)
        else $error("step counter out of range");

    a_pop_wraps_k: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |=> k_reg == '0)
        else $error("step counter did not wrap after the last point");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s0_valid_reg) && $stable(s1_valid_reg) && $stable(s2_valid_reg))
        else $error("pipeline moved during an output stall");

endmodule

[src/cubic_bezier_point_generator.sv]
// Cubic Bezier point generator.
// Input channel (s_valid/s_ready): one transaction carries the four control
// points of a curve, each coordinate signed Q16.4 on its own 20-bit port.
// Output channel (m_valid/m_ready): STEP_COUNT transactions per curve, the
// curve points at t = k/STEP_COUNT for k = 0 .. STEP_COUNT-1, evaluated by
// three levels of de Casteljau interpolation; m_last_point marks k = last.
// The first point of a curve passes through the queue write, the weight issue
// and three interpolation stages before it is valid on the output.
// Throughput: one point per cycle while m_ready is high and a set is queued,
// as the step sequencer issues one weight per cycle; curves run back to back.
// A two-entry queue holds control sets; the curve being evaluated keeps its
// entry until its last point issues, so one more curve can wait behind it.
// With a point in the output register, dropping m_ready holds that register
// and freezes the whole interpolation pipeline; the queue keeps accepting until full.
// Reset (aresetn low, synchronous) empties the queue, clears the step
// counter and drops every pipeline valid; no points are produced.
module cubic_bezier_point_generator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cbez_pkg::coord_t s_start_x,
    input  cbez_pkg::coord_t s_start_y,
    input  cbez_pkg::coord_t s_ctrl_a_x,
    input  cbez_pkg::coord_t s_ctrl_a_y,
    input  cbez_pkg::coord_t s_ctrl_b_x,
    input  cbez_pkg::coord_t s_ctrl_b_y,
    input  cbez_pkg::coord_t s_end_x,
    input  cbez_pkg::coord_t s_end_y,
    output logic             m_valid,
    input  logic             m_ready,
    output cbez_pkg::coord_t m_curve_x,
    output cbez_pkg::coord_t m_curve_y,
    output logic             m_last_point
);
    import cbez_pkg::*;

    ctrl_set_t in_set;
    ctrl_set_t head_data;
    logic      head_valid;
    logic      head_pop;

    always_comb begin
        in_set.x[0] = s_start_x;
        in_set.x[1] = s_ctrl_a_x;
        in_set.x[2] = s_ctrl_b_x;
        in_set.x[3] = s_end_x;
        in_set.y[0] = s_start_y;
        in_set.y[1] = s_ctrl_a_y;
        in_set.y[2] = s_ctrl_b_y;
        in_set.y[3] = s_end_y;
    end

    cbez_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_set      (in_set),
        .head_data  (head_data),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    cbez_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_data    (head_data),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_curve_x    (m_curve_x),
        .m_curve_y    (m_curve_y),
        .m_last_point (m_last_point)
    );

endmodule

[tb/tb_cubic_bezier_point_generator.sv]
`timescale 1ns / 100ps

module tb_cubic_bezier_point_generator;

    import cbez_pkg::*;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } curve_point_t;

    localparam coord_t COORD_MAX = coord_t'(20'h7FFFF);
    localparam coord_t COORD_MIN = coord_t'(20'h80000);
    localparam coord_t COORD_NEG1 = coord_t'(20'hFFFFF);
    localparam longint UNIT_Q16 = 65536;

    logic   aclk;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_start_x = '0;
    coord_t s_start_y = '0;
    coord_t s_ctrl_a_x = '0;
    coord_t s_ctrl_a_y = '0;
    coord_t s_ctrl_b_x = '0;
    coord_t s_ctrl_b_y = '0;
    coord_t s_end_x = '0;
    coord_t s_end_y = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_curve_x;
    coord_t m_curve_y;
    logic   m_last_point;

    curve_point_t pending_points[$];
    int error_count = 0;
    int curves_sent = 0;
    int directed_curves = 0;
    int points_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    cubic_bezier_point_generator DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_ctrl_a_x   (s_ctrl_a_x),
        .s_ctrl_a_y   (s_ctrl_a_y),
        .s_ctrl_b_x   (s_ctrl_b_x),
        .s_ctrl_b_y   (s_ctrl_b_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_curve_x    (m_curve_x),
        .m_curve_y    (m_curve_y),
        .m_last_point (m_last_point)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("** cubic_bezier_point_generator: FAILED **");
        $finish;
    end

    // floor((w1*a + w*b + 32768) / 65536) with Q16 weights
    function automatic longint blend_q16(longint a, longint b, longint w);
        longint acc;
        acc = (UNIT_Q16 - w) * a + w * b + 32768;
        return acc >>> 16;
    endfunction

    function automatic coord_t bezier_value(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
                                            longint w);
        longint l1a, l1b, l1c, l2a, l2b;
        l1a = blend_q16(longint'(p0), longint'(p1), w);
        l1b = blend_q16(longint'(p1), longint'(p2), w);
        l1c = blend_q16(longint'(p2), longint'(p3), w);
        l2a = blend_q16(l1a, l1b, w);
        l2b = blend_q16(l1b, l1c, w);
        return coord_t'(blend_q16(l2a, l2b, w));
    endfunction

    function automatic void queue_curve_points(coord_t sx, coord_t sy, coord_t ax, coord_t ay,
                                               coord_t bx, coord_t by, coord_t ex, coord_t ey);
        curve_point_t pt;
        longint w;
        for (int k = 0; k < STEP_COUNT; k++) begin
            w = (longint'(k) * UNIT_Q16 + STEP_COUNT / 2) / STEP_COUNT;
            pt.x = bezier_value(sx, ax, bx, ex, w);
            pt.y = bezier_value(sy, ay, by, ey, w);
            pt.last = (k == STEP_COUNT - 1);
            pending_points.push_back(pt);
        end
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        curve_point_t exp_pt;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                error_count++;
                $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                         m_curve_x, m_curve_y, m_last_point);
            end else begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (m_curve_x !== exp_pt.x) begin
                    error_count++;
                    $display("%0t: curve_x expected %0d actual %0d", $time, exp_pt.x,
                             m_curve_x);
                end
                if (m_curve_y !== exp_pt.y) begin
                    error_count++;
                    $display("%0t: curve_y expected %0d actual %0d", $time, exp_pt.y,
                             m_curve_y);
                end
                if (m_last_point !== exp_pt.last) begin
                    error_count++;
                    $display("%0t: last_point expected %0b actual %0b", $time, exp_pt.last,
                             m_last_point);
                end
            end
        end
    end

    task automatic send_curve(input coord_t sx, input coord_t sy, input coord_t ax,
                              input coord_t ay, input coord_t bx, input coord_t by,
                              input coord_t ex, input coord_t ey);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_start_x  <= sx;
        s_start_y  <= sy;
        s_ctrl_a_x <= ax;
        s_ctrl_a_y <= ay;
        s_ctrl_b_x <= bx;
        s_ctrl_b_y <= by;
        s_end_x    <= ex;
        s_end_y    <= ey;
        // hold until the transaction is taken
        do begin
            @(posedge aclk);
        end while (!s_ready);
        queue_curve_points(sx, sy, ax, ay, bx, by, ex, ey);
        curves_sent++;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0, 3: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 2047)) - 1024);
            default: begin
                if ($urandom_range(0, 1))
                    return coord_t'(COORD_MAX - coord_t'($urandom_range(0, 15)));
                return coord_t'(COORD_MIN + coord_t'($urandom_range(0, 15)));
            end
        endcase
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_extremes();
        send_curve('0, '0, '0, '0, '0, '0, '0, '0);
        send_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                   COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                   COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                   COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_curve(COORD_NEG1, COORD_NEG1, COORD_NEG1, COORD_NEG1,
                   COORD_NEG1, COORD_NEG1, COORD_NEG1, COORD_NEG1);
        send_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                   COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_curve(coord_t'(1), '0, '0, coord_t'(1), '0, '0, COORD_NEG1, COORD_NEG1);
        send_curve(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        directed_curves += 13;
    endtask

    task automatic test_degenerate();
        coord_t px, py, qx, qy;
        for (int i = 0; i < 3; i++) begin
            px = rand_coord();
            py = rand_coord();
            send_curve(px, py, px, py, px, py, px, py);
        end
        for (int i = 0; i < 3; i++) begin
            px = coord_t'(int'($urandom_range(0, 65535)) - 32768);
            py = coord_t'(int'($urandom_range(0, 65535)) - 32768);
            send_curve(px, py, px + px, py + py, coord_t'(px * 3), coord_t'(py * 3),
                       coord_t'(px * 4), coord_t'(py * 4));
        end
        px = rand_coord();
        py = rand_coord();
        qx = rand_coord();
        qy = rand_coord();
        send_curve(px, py, px, py, qx, qy, qx, qy);
        send_curve(px, py, qx, qy, px, py, qx, qy);
        directed_curves += 8;
    endtask

    task automatic test_random_curves(input int count);
        coord_t px, py;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                px = rand_coord();
                py = rand_coord();
                send_curve(px, py, px, py, rand_coord(), rand_coord(), px, py);
            end else begin
                send_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(8, 67);
        test_extremes();
        test_random_curves(110);

        set_idle(67, 8);
        test_degenerate();
        test_random_curves(110);

        set_idle(0, 0);
        test_random_curves(120);

        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);

        $display("Run covered %0d curves (%0d directed), %0d curve points checked,",
                 curves_sent, directed_curves, points_checked);
        $display("under sender-heavy, receiver-heavy and back-to-back flow control.");
        if (error_count == 0) begin
            $display("** cubic_bezier_point_generator: PASSED **");
        end else begin
            $display("** cubic_bezier_point_generator: FAILED **");
        end
        $finish;
    end

endmodule
